/* hdl/rolling_canonical_kmer_encoder_core_defines.svh */
// Assertion macros used by the port-level checker of the k-mer encoder
`ifndef ROLLING_CANONICAL_KMER_ENCODER_CORE_DEFINES_SVH
`define ROLLING_CANONICAL_KMER_ENCODER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RCKE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define RCKE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/rcke_pkg.sv */
// Package: types and constants of the rolling canonical k-mer encoder
package rcke_pkg;

  localparam int MAX_KMER_LENGTH = 32;
  localparam int NUM_CELLS       = MAX_KMER_LENGTH;
  localparam int KMER_BITS       = 64;
  localparam int K_W             = 6;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 6;

  localparam logic [K_W-1:0] K_RESET = K_W'(31);
  localparam logic [1:0]     COMP_MASK = 2'b10;

  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BINARY_INPUT = 1'b1;

  typedef struct packed {
    logic [7:0] nucleotide;
    logic       restart;
  } in_word_t;

  typedef struct packed {
    logic [KMER_BITS-1:0] canonical_code;
    logic [KMER_BITS-1:0] forward_kmer;
    logic [KMER_BITS-1:0] reverse_kmer;
  } out_word_t;

  // per-step control broadcast to every cell of the window chain
  typedef struct packed {
    logic       advance;
    logic       restart;
    logic [1:0] code;
    logic [1:0] comp;
  } cell_ctl_t;

endpackage

/* hdl/rcke_cell.sv */
// One window position: forward and reverse-complement nucleotide codes
module rcke_cell
  import rcke_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctl_t  ctl,
  input  logic       is_first,
  input  logic       is_top,
  input  logic       in_window,
  input  logic [1:0] fwd_left,
  input  logic [1:0] rev_right,
  output logic [1:0] fwd,
  output logic [1:0] rev,
  output logic [1:0] fwd_next,
  output logic [1:0] rev_next
);

  logic [1:0] fwd_src;
  logic [1:0] rev_src;

  always_comb begin
    // neighbors read as empty on the first nucleotide of a read
    fwd_src  = is_first ? ctl.code : (ctl.restart ? 2'b00 : fwd_left);
    rev_src  = (ctl.restart ? 2'b00 : rev_right) | (is_top ? ctl.comp : 2'b00);
    fwd_next = in_window ? fwd_src : 2'b00;
    rev_next = in_window ? rev_src : 2'b00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 2'b00;
      rev <= 2'b00;
    end else if (ctl.advance) begin
      fwd <= fwd_next;
      rev <= rev_next;
    end
  end

endmodule

/* hdl/rcke_out_stage.sv */
// Output register: canonical selection and result word holding
module rcke_out_stage
  import rcke_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [KMER_BITS-1:0] fwd_vec,
  input  logic [KMER_BITS-1:0] rev_vec,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data
);

  out_word_t word_next;

  always_comb begin
    word_next.forward_kmer   = fwd_vec;
    word_next.reverse_kmer   = rev_vec;
    word_next.canonical_code = (fwd_vec < rev_vec) ? fwd_vec : rev_vec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= word_next;
    end
  end

endmodule

/* hdl/rolling_canonical_kmer_encoder_core.sv */
// Top level: rolling canonical k-mer encoder built from a chain of window cells
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one nucleotide per word,
//   an ASCII letter coded by bits 2:1 or a raw 2-bit code, plus a restart flag
//   that opens a new read. Output channel (out_valid/out_stall/out_data)
//   carries the canonical, forward and reverse-complement codes.
//   A window cell per nucleotide position shifts forward codes up the chain
//   and reverse-complement codes down it, all cells moving in the same cycle.
//   The result word is registered at the edge that accepts the word that completes it.
//   Throughput: one nucleotide per cycle while in_stall is low.
//   No result leaves until the window holds kmer_length nucleotides.
//   Reset clears the window and fill count and sets kmer_length to 31 and
//   binary_input to 0. When the receiver stalls with a result pending,
//   in_stall goes high and the held result stays unchanged.
//   Configuration writes (cfg_we/cfg_index/cfg_data) take effect on the next
//   word; kmer_length 0 acts as 1 and values above 32 act as 32.
module rolling_canonical_kmer_encoder_core
  import rcke_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data
);

  logic [K_W-1:0] k_eff;
  logic           binary_input;
  logic [K_W-1:0] fill;
  logic [K_W-1:0] fill_next;
  logic [K_W:0]   fill_inc;
  logic           accept;
  logic           emit;
  logic           load;
  cell_ctl_t      ctl;

  logic [1:0] fwd_q [NUM_CELLS];
  logic [1:0] rev_q [NUM_CELLS];
  logic [1:0] fwd_next [NUM_CELLS];
  logic [1:0] rev_next [NUM_CELLS];
  logic [KMER_BITS-1:0] fwd_vec;
  logic [KMER_BITS-1:0] rev_vec;

  // configuration registers; the window length is clamped when written
  always_ff @(posedge clk) begin
    if (rst) begin
      k_eff        <= K_RESET;
      binary_input <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KMER_LENGTH: begin
          if (cfg_data[K_W-1:0] == '0) begin
            k_eff <= K_W'(1);
          end else if (cfg_data[K_W-1:0] > K_W'(MAX_KMER_LENGTH)) begin
            k_eff <= K_W'(MAX_KMER_LENGTH);
          end else begin
            k_eff <= cfg_data[K_W-1:0];
          end
        end
        CFG_BINARY_INPUT: begin
          binary_input <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    ctl.advance = accept;
    ctl.restart = in_data.restart;
    ctl.code    = binary_input ? in_data.nucleotide[1:0] : in_data.nucleotide[2:1];
    ctl.comp    = ctl.code ^ COMP_MASK;
  end

  // fill count saturates at the window length
  always_comb begin
    fill_inc = {1'b0, (in_data.restart ? {K_W{1'b0}} : fill)} + (K_W+1)'(1);
    if (fill_inc > {1'b0, k_eff}) begin
      fill_next = k_eff;
    end else begin
      fill_next = fill_inc[K_W-1:0];
    end
    emit = (fill_next == k_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    logic [1:0] fwd_left;
    logic [1:0] rev_right;

    if (i == 0) begin : g_first
      assign fwd_left = 2'b00;
    end else begin : g_mid
      assign fwd_left = fwd_q[i-1];
    end

    if (i == NUM_CELLS - 1) begin : g_last
      assign rev_right = 2'b00;
    end else begin : g_inner
      assign rev_right = rev_q[i+1];
    end

    rcke_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .is_first  (i == 0),
      .is_top    (K_W'(i + 1) == k_eff),
      .in_window (K_W'(i) < k_eff),
      .fwd_left  (fwd_left),
      .rev_right (rev_right),
      .fwd       (fwd_q[i]),
      .rev       (rev_q[i]),
      .fwd_next  (fwd_next[i]),
      .rev_next  (rev_next[i])
    );
  end

  // gather the window as it stands after the accepted word
  always_comb begin
    fwd_vec = '0;
    rev_vec = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      fwd_vec[2*i +: 2] = fwd_next[i];
      rev_vec[2*i +: 2] = rev_next[i];
    end
  end

  // load the result word at the edge that accepts the completing word
  assign load = accept && emit;

  rcke_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .fwd_vec   (fwd_vec),
    .rev_vec   (rev_vec),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* hdl/rcke_checker.sv */
// Port-level checker for the k-mer encoder, bound to the top level
`include "rolling_canonical_kmer_encoder_core_defines.svh"

module rcke_checker
  import rcke_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input out_word_t             out_data
);

  `RCKE_ASSERT_NOW(a_canonical_min, clk, rst, out_valid, out_data.canonical_code == ((out_data.forward_kmer < out_data.reverse_kmer) ? out_data.forward_kmer : out_data.reverse_kmer), "canonical code is not the smaller code")

  `RCKE_ASSERT_NOW(a_stall_cause, clk, rst, in_stall, out_valid && out_stall, "input stalled without a blocked result")

  `RCKE_ASSERT_NOW(a_result_source, clk, rst, out_valid && !$past(out_valid), $past(in_valid && !in_stall), "result without a preceding input word")

  `RCKE_ASSERT_NEXT(a_hold_result, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed or dropped")

endmodule

bind rolling_canonical_kmer_encoder_core rcke_checker u_rcke_checker (.*);
